// ----- src/wpwr_pkg.sv -----
// Shared types and constants for the weighted pick without replacement block.
package wpwr_pkg;

    localparam int KIND_W = 2;
    localparam int KEY_W  = 16;
    localparam int WGT_W  = 16;
    localparam int RND_W  = 31;
    localparam int SUM_W  = 22;
    localparam int STAT_W = 3;
    localparam int PIDX_W = 6;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_CHOOSE = 2'd2
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE   = 3'd0,
        STAT_FULL   = 3'd1,
        STAT_PICKED = 3'd2,
        STAT_RETRY  = 3'd3,
        STAT_NONE   = 3'd4,
        STAT_ZERO   = 3'd5
    } status_t;

    // One table row: picked flag, key and running weight sum.
    typedef struct packed {
        logic             picked;
        logic [KEY_W-1:0] key;
        logic [SUM_W-1:0] sum;
    } entry_t;

    // Data handed from one divider cell to the next.
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] rem;
        logic [RND_W-1:0] word;
    } div_link_t;

endpackage

// ----- src/wpwr_div_cell.sv -----
// One restoring-division cell: folds in one dividend bit and passes on.
module wpwr_div_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wpwr_pkg::div_link_t             link_in,
    input  logic [wpwr_pkg::SUM_W-1:0]      divisor,
    output wpwr_pkg::div_link_t             link_out
);
    import wpwr_pkg::*;

    logic             valid_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [RND_W-1:0] word_reg;
    logic [SUM_W-1:0] rem_next;
    logic [RND_W-1:0] word_next;
    logic [SUM_W:0]   trial;
    logic [SUM_W+1:0] diff;

    always_comb
    begin
        trial     = {link_in.rem, link_in.word[RND_W-1]};
        diff      = {1'b0, trial} - {2'b00, divisor};
        // keep the shifted remainder when the subtraction goes negative
        rem_next  = diff[SUM_W+1] ? trial[SUM_W-1:0] : diff[SUM_W-1:0];
        word_next = {link_in.word[RND_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= link_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        word_reg <= word_next;
    end

    assign link_out = '{valid: valid_reg, rem: rem_reg, word: word_reg};

endmodule

// ----- src/wpwr_div_chain.sv -----
// Row of division cells that reduces the random word modulo the total weight.
module wpwr_div_chain (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wpwr_pkg::div_link_t             link_in,
    input  logic [wpwr_pkg::SUM_W-1:0]      divisor,
    output logic                            rem_valid,
    output logic [wpwr_pkg::SUM_W-1:0]      rem
);
    import wpwr_pkg::*;

    div_link_t links [RND_W+1];

    assign links[0] = link_in;

    for (genvar i = 0; i < RND_W; i++)
    begin : g_cell
        wpwr_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (links[i]),
            .divisor  (divisor),
            .link_out (links[i+1])
        );
    end

    assign rem_valid = links[RND_W].valid;
    assign rem       = links[RND_W].rem;

endmodule

// ----- src/wpwr_table.sv -----
// Entry table memory: one write port, one registered read port.
module wpwr_table #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wpwr_pkg::entry_t           wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output wpwr_pkg::entry_t           rd_data
);
    import wpwr_pkg::*;

    entry_t store_reg [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/weighted_pick_without_replacement.sv -----
// Top level: weighted pick without replacement over a table of keyed entries.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------------
//   item in  | start high, busy low   | kind, entry_key, entry_weight, random_word
//   result   | done (one-cycle pulse) | status, picked_key, picked_index
//
// Clear, append, unknown kinds and choose items that hit no entry give their
// result in the cycle after acceptance, and busy stays low, so such items can
// follow every cycle. A choose item that searches sends the word through the
// division chain, then runs at most ceil(log2(entry count)) binary search steps,
// each a read on the table's registered read port and a compare, and then reads
// and updates the hit entry. busy drops as done rises.
// Reset (rst_n, asynchronous) empties the table; no sweep is needed because
// rows are rewritten on append. The receiver cannot stall: done lasts one cycle.
module weighted_pick_without_replacement #(
    parameter int CAPACITY = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [wpwr_pkg::KIND_W-1:0]       kind,
    input  logic [wpwr_pkg::KEY_W-1:0]        entry_key,
    input  logic [wpwr_pkg::WGT_W-1:0]        entry_weight,
    input  logic [wpwr_pkg::RND_W-1:0]        random_word,
    output logic                              done,
    output logic [wpwr_pkg::STAT_W-1:0]       status,
    output logic [wpwr_pkg::KEY_W-1:0]        picked_key,
    output logic [wpwr_pkg::PIDX_W-1:0]       picked_index
);
    import wpwr_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_DIVIDE  = 5'b00010,
        S_SEARCH  = 5'b00100,
        S_COMPARE = 5'b01000,
        S_FETCH   = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [SUM_W-1:0] total_reg, total_next;
    logic [SUM_W-1:0] target_reg, target_next;
    logic [IDX_W-1:0] lo_reg, lo_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic             done_reg, done_next;
    status_t          status_reg, status_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [PIDX_W-1:0] index_reg, index_next;

    logic [IDX_W:0]          mid_sum;
    logic [IDX_W-1:0]        mid;
    logic [CNT_W-1:0]        last_idx;
    logic [IDX_W+PIDX_W-1:0] lo_ext;
    logic [SUM_W-1:0]        weight_ext;
    logic [SUM_W-1:0]        new_total;

    div_link_t        launch;
    logic             rem_valid;
    logic [SUM_W-1:0] rem;

    logic             tbl_we;
    logic [IDX_W-1:0] tbl_waddr;
    entry_t           tbl_wdata;
    logic             tbl_re;
    logic [IDX_W-1:0] tbl_raddr;
    entry_t           tbl_rdata;

    wpwr_div_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .link_in   (launch),
        .divisor   (total_reg),
        .rem_valid (rem_valid),
        .rem       (rem)
    );

    wpwr_table #(
        .DEPTH (CAPACITY)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata),
        .rd_en   (tbl_re),
        .rd_addr (tbl_raddr),
        .rd_data (tbl_rdata)
    );

    // midpoint of the search window, computed one bit wider to avoid overflow
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid        = mid_sum[IDX_W:1];
    assign last_idx   = count_reg - CNT_W'(1);
    assign lo_ext     = {{PIDX_W{1'b0}}, lo_reg};
    assign weight_ext = {{(SUM_W-WGT_W){1'b0}}, entry_weight};
    // the previous running sum always equals the total, both wrap alike
    assign new_total  = total_reg + weight_ext;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        left_next   = left_reg;
        total_next  = total_reg;
        target_next = target_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        key_next    = key_reg;
        index_next  = index_reg;

        launch      = '{valid: 1'b0, rem: '0, word: random_word};

        tbl_we      = 1'b0;
        tbl_waddr   = count_reg[IDX_W-1:0];
        tbl_wdata   = '{picked: 1'b0, key: entry_key, sum: new_total};
        tbl_re      = 1'b0;
        tbl_raddr   = (lo_reg == hi_reg) ? lo_reg : mid;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // default result for items that hit no entry
                    done_next   = 1'b1;
                    status_next = STAT_DONE;
                    key_next    = '0;
                    index_next  = '0;
                    unique case (kind)
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            left_next  = '0;
                            total_next = '0;
                        end
                        KIND_APPEND:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                tbl_we     = 1'b1;
                                total_next = new_total;
                                count_next = count_reg + CNT_W'(1);
                                left_next  = left_reg + CNT_W'(1);
                            end
                        end
                        KIND_CHOOSE:
                        begin
                            if (left_reg == '0 || count_reg == '0)
                            begin
                                status_next = STAT_NONE;
                            end
                            else if (total_reg == '0)
                            begin
                                status_next = STAT_ZERO;
                            end
                            else
                            begin
                                // hand the word to the division chain and hold
                                done_next    = 1'b0;
                                launch.valid = 1'b1;
                                state_next   = S_DIVIDE;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_DONE;
                        end
                    endcase
                end
            end
            S_DIVIDE:
            begin
                if (rem_valid)
                begin
                    target_next = rem;
                    lo_next     = '0;
                    hi_next     = last_idx[IDX_W-1:0];
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                // read the midpoint, or the hit entry once the window closes
                tbl_re     = 1'b1;
                state_next = (lo_reg == hi_reg) ? S_FETCH : S_COMPARE;
            end
            S_COMPARE:
            begin
                if (tbl_rdata.sum > target_reg)
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = mid + IDX_W'(1);
                end
                state_next = S_SEARCH;
            end
            S_FETCH:
            begin
                done_next  = 1'b1;
                key_next   = tbl_rdata.key;
                index_next = lo_ext[PIDX_W-1:0];
                if (tbl_rdata.picked)
                begin
                    status_next = STAT_RETRY;
                end
                else
                begin
                    // mark the entry picked and drop it from the remaining count
                    status_next = STAT_PICKED;
                    tbl_we      = 1'b1;
                    tbl_waddr   = lo_reg;
                    tbl_wdata   = '{picked: 1'b1, key: tbl_rdata.key, sum: tbl_rdata.sum};
                    left_next   = left_reg - CNT_W'(1);
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            left_reg  <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        status_reg <= status_next;
        key_reg    <= key_next;
        index_reg  <= index_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign picked_key   = key_reg;
    assign picked_index = index_reg;

endmodule

// ----- src/wpwr_checker.sv -----
// Port-level checks for the weighted pick block, bound to the top level.
module wpwr_port_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [wpwr_pkg::KIND_W-1:0]       kind,
    input logic                              done,
    input logic [wpwr_pkg::STAT_W-1:0]       status,
    input logic [wpwr_pkg::KEY_W-1:0]        picked_key,
    input logic [wpwr_pkg::PIDX_W-1:0]       picked_index
);
    import wpwr_pkg::*;

    // items other than choose finish in the next cycle
    a_short_item: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && kind != KIND_CHOOSE |=> done && !busy)
        else $error("short item gave no result in the next cycle");

    // a choose item either ends at once with no hit, or keeps the block busy
    a_choose_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && kind == KIND_CHOOSE |=>
            (done && (status == STAT_NONE || status == STAT_ZERO)) || (busy && !done))
        else $error("choose item started wrongly");

    // results that hit no entry carry zero key and index
    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == STAT_DONE || status == STAT_FULL ||
                 status == STAT_NONE || status == STAT_ZERO) |->
            picked_key == '0 && picked_index == '0)
        else $error("result without a hit carries key or index");

    // a hit is only reported at the end of a search
    a_hit_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == STAT_PICKED || status == STAT_RETRY) |-> $past(busy) && !busy)
        else $error("hit reported without a search");

endmodule

bind weighted_pick_without_replacement wpwr_port_checker u_wpwr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .done         (done),
    .status       (status),
    .picked_key   (picked_key),
    .picked_index (picked_index)
);

// ----- tb/wpwr_checker.sv -----
`timescale 1ns / 1ps
// Checker for the weighted pick block: mirrors the table, predicts each result and compares it.
module wpwr_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [wpwr_pkg::KIND_W-1:0] kind,
    input  logic [wpwr_pkg::KEY_W-1:0]  entry_key,
    input  logic [wpwr_pkg::WGT_W-1:0]  entry_weight,
    input  logic [wpwr_pkg::RND_W-1:0]  random_word,
    input  logic                        done,
    input  logic [wpwr_pkg::STAT_W-1:0] status,
    input  logic [wpwr_pkg::KEY_W-1:0]  picked_key,
    input  logic [wpwr_pkg::PIDX_W-1:0] picked_index,
    output int                          fail_count,
    output int                          pending
);
    import wpwr_pkg::*;

    typedef struct {
        status_t           status;
        logic [KEY_W-1:0]  key;
        logic [PIDX_W-1:0] index;
    } outcome_t;

    // Shadow copy of the table and its counters.
    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [SUM_W-1:0] sum_mem [CAPACITY];
    bit               taken   [CAPACITY];
    int unsigned      filled;
    int unsigned      unpicked;
    logic [SUM_W-1:0] total;

    outcome_t         awaited_outcomes[$];
    outcome_t         want;

    // First slot whose running sum is above target.
    function automatic int unsigned locate_slot(input logic [SUM_W-1:0] target);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = filled - 1;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (sum_mem[mid] > target)
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    // Apply one item to the shadow table and return the result it must give.
    function automatic outcome_t apply_item(
        input logic [KIND_W-1:0] k,
        input logic [KEY_W-1:0]  key_in,
        input logic [WGT_W-1:0]  wgt,
        input logic [RND_W-1:0]  rnd
    );
        outcome_t         o;
        logic [SUM_W-1:0] prev;
        int unsigned      slot;
        o.status = STAT_DONE;
        o.key    = '0;
        o.index  = '0;
        case (k)
            KIND_CLEAR:
            begin
                filled   = 0;
                unpicked = 0;
                total    = '0;
                foreach (taken[i])
                    taken[i] = 1'b0;
            end
            KIND_APPEND:
            begin
                if (filled >= CAPACITY)
                    o.status = STAT_FULL;
                else
                begin
                    prev = (filled == 0) ? '0 : sum_mem[filled-1];
                    key_mem[filled] = key_in;
                    sum_mem[filled] = prev + SUM_W'(wgt);
                    total = total + SUM_W'(wgt);
                    filled++;
                    unpicked++;
                end
            end
            KIND_CHOOSE:
            begin
                if (unpicked == 0 || filled == 0)
                    o.status = STAT_NONE;
                else if (total == '0)
                    o.status = STAT_ZERO;
                else
                begin
                    slot = locate_slot(SUM_W'(rnd % total));
                    o.key   = key_mem[slot];
                    o.index = PIDX_W'(slot);
                    if (taken[slot])
                        o.status = STAT_RETRY;
                    else
                    begin
                        taken[slot] = 1'b1;
                        unpicked--;
                        o.status = STAT_PICKED;
                    end
                end
            end
            default:
                ;
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled     = 0;
            unpicked   = 0;
            total      = '0;
            fail_count = 0;
            pending    = 0;
            foreach (taken[i])
                taken[i] = 1'b0;
            awaited_outcomes.delete();
        end
        else
        begin
            // Retire the result first: it belongs to an item taken at an earlier edge.
            if (done)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    $error("result with no item waiting: status %0d key %0h index %0d",
                           status, picked_key, picked_index);
                    fail_count++;
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (picked_key !== want.key)
                    begin
                        $error("picked_key mismatch: expected %0h, actual %0h",
                               want.key, picked_key);
                        fail_count++;
                    end
                    if (picked_index !== want.index)
                    begin
                        $error("picked_index mismatch: expected %0d, actual %0d",
                               want.index, picked_index);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                awaited_outcomes.push_back(apply_item(kind, entry_key, entry_weight, random_word));
            pending = awaited_outcomes.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Testbench top for the weighted pick block: clock, reset, item stimulus and verdict.
module testbench;
    import wpwr_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int ITEM_TARGET = 850;
    // Stretch of items sent with no random idle gaps; drains can still pause the sender.
    localparam int QUIET_FROM  = 380;
    localparam int QUIET_TO    = 560;
    // Settle time after the drain; plenty of slack over a searching choose at full table.
    localparam int SETTLE_CYCLES = 100;
    // Kind code the block must ignore.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              start        = 1'b0;
    logic [KIND_W-1:0] kind         = KIND_CLEAR;
    logic [KEY_W-1:0]  entry_key    = '0;
    logic [WGT_W-1:0]  entry_weight = '0;
    logic [RND_W-1:0]  random_word  = '0;
    logic              busy;
    logic              done;
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  picked_key;
    logic [PIDX_W-1:0] picked_index;

    int                fail_count;
    int                pending;
    int                items_sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    weighted_pick_without_replacement #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .entry_key    (entry_key),
        .entry_weight (entry_weight),
        .random_word  (random_word),
        .done         (done),
        .status       (status),
        .picked_key   (picked_key),
        .picked_index (picked_index)
    );

    wpwr_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .entry_key    (entry_key),
        .entry_weight (entry_weight),
        .random_word  (random_word),
        .done         (done),
        .status       (status),
        .picked_key   (picked_key),
        .picked_index (picked_index),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Random word with its extremes drawn now and then.
    function automatic logic [RND_W-1:0] draw_word();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return RND_W'($urandom);
        endcase
    endfunction

    // Idle at random, then hold the item on the ports until the block takes it.
    // Call and return at a falling edge; start stays high so the next item can
    // follow without a gap.
    task automatic send_item(
        input logic [KIND_W-1:0] k,
        input logic [KEY_W-1:0]  key_in,
        input logic [WGT_W-1:0]  wgt,
        input logic [RND_W-1:0]  rnd
    );
        bit accepted;
        int gap;
        if ((items_sent < QUIET_FROM || items_sent >= QUIET_TO) && $urandom_range(0, 99) < 18)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start        <= 1'b1;
        kind         <= k;
        entry_key    <= key_in;
        entry_weight <= wgt;
        random_word  <= rnd;
        do
        begin
            @(posedge clk);
            accepted = !busy;
            @(negedge clk);
        end
        while (!accepted);
        items_sent++;
    endtask

    // Drop start and hold off until every expected result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                n;
        int                mode;
        int                chooses;
        int                runs;
        logic [WGT_W-1:0]  w;

        runs = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty table, unknown kind, all-zero weights.
        send_item(KIND_CHOOSE, '0, '0, '0);
        send_item(KIND_UNUSED, '1, '1, '1);
        send_item(KIND_APPEND, '1, '0, '0);
        send_item(KIND_APPEND, '0, '0, '1);
        send_item(KIND_CHOOSE, '0, '0, '1);
        send_item(KIND_CLEAR, '1, '1, '1);

        // Sums 1, 65536, 65536, 65537: extreme weights and a zero-weight slot.
        send_item(KIND_APPEND, 16'h1234, 16'd1, '0);
        send_item(KIND_APPEND, '1, '1, '0);
        send_item(KIND_APPEND, '0, '0, '0);
        send_item(KIND_APPEND, 16'h5A5A, 16'd1, '0);
        send_item(KIND_CHOOSE, '0, '0, '0);
        // Same target again hits the entry already picked.
        send_item(KIND_CHOOSE, '0, '0, '0);
        send_item(KIND_CHOOSE, '0, '0, '1);
        send_item(KIND_CHOOSE, '0, '0, 31'd65536);
        send_item(KIND_CHOOSE, '0, '0, 31'd1);
        // Only the zero-weight slot is left; it can never be hit.
        send_item(KIND_CHOOSE, '0, '0, '0);
        send_item(KIND_CLEAR, '0, '0, '0);
        send_item(KIND_CHOOSE, '1, '1, '1);

        // Pause the sender until the block has answered everything.
        wait_for_results();

        // Random part: mostly clear / fill / choose runs, some loose noise items.
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 99) < 5)
                wait_for_results();
            if ($urandom_range(0, 99) < 75)
            begin
                send_item(KIND_CLEAR, KEY_W'($urandom), WGT_W'($urandom), draw_word());
                // Mostly small tables; the first run overfills to reach the full case.
                case ($urandom_range(0, 99)) inside
                    [0:79]:  n = $urandom_range(1, 10);
                    [80:91]: n = $urandom_range(11, 40);
                    default: n = CAPACITY + $urandom_range(1, 3);
                endcase
                if (runs == 0)
                    n = CAPACITY + 2;
                runs++;
                mode = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                begin
                    case (mode)
                        0:       w = WGT_W'($urandom_range(0, 15));
                        1:       w = WGT_W'($urandom);
                        2:       w = '0;
                        3:       w = $urandom_range(0, 1) ? '1 : '0;
                        default: w = $urandom_range(0, 1) ? '0 : WGT_W'($urandom_range(1, 255));
                    endcase
                    send_item(KIND_APPEND, KEY_W'($urandom), w, draw_word());
                end
                // Choose past exhaustion so retries and none-left both show up.
                chooses = 2 * ((n > CAPACITY) ? CAPACITY : n) + $urandom_range(1, 4);
                for (int i = 0; i < chooses; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(KIND_W'($urandom_range(0, 3)), KEY_W'($urandom),
                                  WGT_W'($urandom), draw_word());
                    send_item(KIND_CHOOSE, KEY_W'($urandom), WGT_W'($urandom), draw_word());
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_item(KIND_W'($urandom_range(0, 3)), KEY_W'($urandom),
                              WGT_W'($urandom), draw_word());
            end
        end

        // Drain, let the block settle, then give the verdict.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: even with every item a full search after the longest gap, a
    // correct run needs under a quarter of this.
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
